// ----- design/sfbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfbc_pkg: shared types and constants of the sorted flow byte counter
// token carried along the cell chain, mode and outcome codes, field widths
// ----------------------------------------------------------------------------
package sfbc_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned KeyW        = 104;
  localparam int unsigned TotalW      = 64;
  localparam int unsigned AddrW       = 32;
  localparam int unsigned PortW       = 16;
  localparam int unsigned ProtoW      = 8;
  localparam int unsigned BytesW      = 32;
  localparam int unsigned OutcomeW    = 2;

  localparam logic [AddrW-1:0] MaskReset = 32'hf8ff_ffff;

  // token modes
  localparam logic [1:0] ModeSearch = 2'd0;
  localparam logic [1:0] ModeCarry  = 2'd1;
  localparam logic [1:0] ModeDone   = 2'd2;

  // result outcomes
  localparam logic [OutcomeW-1:0] OutUpdate = 2'd0;
  localparam logic [OutcomeW-1:0] OutInsert = 2'd1;
  localparam logic [OutcomeW-1:0] OutDrop   = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [1:0]          mode;
    logic [OutcomeW-1:0] outcome;
    logic [KeyW-1:0]     key;
    logic [TotalW-1:0]   data;
  } sfbc_token_t;

endpackage : sfbc_pkg
`default_nettype wire

// ----- design/sfbc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfbc_cell: one table entry of the sorted flow chain
// holds one key and its byte total, searches, updates or inserts, and hands
// the token (or the displaced entry) to its right-hand neighbour
// ----------------------------------------------------------------------------
module sfbc_cell #(
  parameter int unsigned CAPACITY = sfbc_pkg::CapacityDef,
  parameter int unsigned INDEX    = 0
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire [$clog2(CAPACITY+1)-1:0]       count_i,
  input  wire                                full_i,
  input  wire sfbc_pkg::sfbc_token_t         tok_i,
  output sfbc_pkg::sfbc_token_t              tok_o
);
  import sfbc_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [KeyW-1:0]   key_q, key_d;
  logic [TotalW-1:0] total_q, total_d;
  logic              we;
  sfbc_token_t       tok_q, tok_d;
  logic              occ;
  logic [TotalW-1:0] sum;

  // entries are packed from index 0 upwards
  assign occ = count_i > CntW'(INDEX);
  assign sum = total_q + tok_i.data;

  always_comb begin
    tok_d   = tok_i;
    key_d   = key_q;
    total_d = total_q;
    we      = 1'b0;
    if (tok_i.valid) begin
      unique case (tok_i.mode)
        ModeSearch: begin
          if (occ && (key_q < tok_i.key)) begin
            tok_d = tok_i;
          end else if (occ && (key_q == tok_i.key)) begin
            we           = 1'b1;
            total_d      = sum;
            tok_d.mode    = ModeDone;
            tok_d.outcome = OutUpdate;
            tok_d.data    = sum;
          end else if (full_i) begin
            tok_d.mode    = ModeDone;
            tok_d.outcome = OutDrop;
            tok_d.data    = '0;
          end else begin
            we            = 1'b1;
            key_d         = tok_i.key;
            total_d       = tok_i.data;
            tok_d.outcome = OutInsert;
            tok_d.mode    = occ ? ModeCarry : ModeDone;
            tok_d.key     = key_q;
            tok_d.data    = total_q;
          end
        end
        ModeCarry: begin
          // displaced entry moves up by one place
          we         = 1'b1;
          key_d      = tok_i.key;
          total_d    = tok_i.data;
          tok_d.mode = occ ? ModeCarry : ModeDone;
          tok_d.key  = key_q;
          tok_d.data = total_q;
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_q   <= key_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule : sfbc_cell
`default_nettype wire

// ----- design/sorted_flow_byte_counter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_flow_byte_counter: per-flow byte totals in a sorted cell chain
// keeps up to CAPACITY five-tuple flows in key order with 64-bit totals
// ----------------------------------------------------------------------------
// One flow record is taken per input beat. Its source address is ANDed with
// the mask register, then the record travels as a token along a chain of
// CAPACITY cells, one cell per clock. Each cell holds one flow in sorted
// order of (protocol, source, destination, source port, destination port).
// A matching cell adds the byte count to its total; otherwise the first cell
// holding a larger key (or the first empty cell) takes the new flow and the
// larger entries ripple up one place behind the token. A new flow arriving
// with the table full is dropped and flagged. One record is in the chain at
// a time, so the next input beat is taken only after the previous record
// has left the chain and its result has moved on from the pending register.
// The finished result sits in an output register, so the next record is
// accepted while the previous result is still waiting on the master side.
// The mask may be written only while the block is idle.
// ----------------------------------------------------------------------------
module sorted_flow_byte_counter #(
  parameter int unsigned CAPACITY = sfbc_pkg::CapacityDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  // configuration: source address mask
  input  wire          cfg_we_i,
  input  wire  [31:0]  cfg_wdata_i,
  // flow records in
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // protocol[7:0], source_address[39:8], dest_address[71:40],
  // source_port[87:72], dest_port[103:88], byte_count[135:104]
  input  wire  [135:0] s_axis_tdata,
  // results out
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // flow_total[63:0], outcome[65:64], entries_used above that, zero padded
  output logic [((66+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata
);
  import sfbc_pkg::*;

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned ResW  = TotalW + OutcomeW + CntW;
  localparam int unsigned OutDW = ((ResW + 7) / 8) * 8;

  // input fields
  logic [ProtoW-1:0] in_proto;
  logic [AddrW-1:0]  in_sip, in_dip;
  logic [PortW-1:0]  in_sport, in_dport;
  logic [BytesW-1:0] in_bytes;

  assign in_proto = s_axis_tdata[7:0];
  assign in_sip   = s_axis_tdata[39:8];
  assign in_dip   = s_axis_tdata[71:40];
  assign in_sport = s_axis_tdata[87:72];
  assign in_dport = s_axis_tdata[103:88];
  assign in_bytes = s_axis_tdata[135:104];

  logic [AddrW-1:0]  mask_q;
  logic [CntW-1:0]   count_q;
  logic              busy_q;
  logic [BytesW-1:0] add_q;
  logic              full;
  logic              in_beat;

  // token chain: tok[0] is the entry register, tok[CAPACITY] the tail
  sfbc_token_t       tok [CAPACITY+1];
  sfbc_token_t       tok0_q;
  logic [CAPACITY:0] tok_valid;

  // pending result and output register
  logic              pend_valid_q;
  logic [ResW-1:0]   pend_q;
  logic              out_valid_q;
  logic [ResW-1:0]   out_q;

  logic [OutcomeW-1:0] tail_outcome;
  logic [TotalW-1:0]   tail_total;
  logic [CntW-1:0]     tail_count;
  logic                pend_move;

  assign full          = count_q == CntW'(CAPACITY);
  assign s_axis_tready = !busy_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskReset;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  // entry token, key packed with protocol in the top bits so that one
  // unsigned compare gives the lexicographic order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= '0;
    end else begin
      tok0_q.valid <= in_beat;
      if (in_beat) begin
        tok0_q.mode    <= ModeSearch;
        tok0_q.outcome <= OutInsert;
        tok0_q.key     <= {in_proto, in_sip & mask_q, in_dip, in_sport, in_dport};
        tok0_q.data    <= {{(TotalW-BytesW){1'b0}}, in_bytes};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      add_q <= in_bytes;
    end
  end

  assign tok[0]       = tok0_q;
  assign tok_valid[0] = tok[0].valid;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sfbc_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .full_i  (full),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1])
    );
    assign tok_valid[i+1] = tok[i+1].valid;
  end

  // a token still searching at the tail found no place in a full table
  always_comb begin
    tail_outcome = (tok[CAPACITY].mode == ModeSearch) ? OutDrop : tok[CAPACITY].outcome;
    case (tail_outcome)
      OutInsert: tail_total = {{(TotalW-BytesW){1'b0}}, add_q};
      OutUpdate: tail_total = tok[CAPACITY].data;
      default:   tail_total = '0;
    endcase
    tail_count = (tail_outcome == OutInsert) ? count_q + CntW'(1) : count_q;
  end

  assign pend_move = pend_valid_q && (!out_valid_q || m_axis_tready);

  // control: busy from input beat until the result reaches the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_beat) begin
        busy_q <= 1'b1;
      end else if (pend_move) begin
        busy_q <= 1'b0;
      end
      if (tok[CAPACITY].valid) begin
        count_q      <= tail_count;
        pend_valid_q <= 1'b1;
      end else if (pend_move) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok[CAPACITY].valid) begin
      pend_q <= {tail_count, tail_outcome, tail_total};
    end
    if (pend_move) begin
      out_q <= pend_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDW-ResW){1'b0}}, out_q};

  // ---------------------------------------------------------------- checks
  // never more flows than cells
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("flow count beyond capacity");

  // only one record travels the chain at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_valid))
    else $error("more than one token in the cell chain");

  // the flow count only ever grows by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CntW'(1)))
    else $error("flow count changed by more than one");

  // a token or pending result only exists while an item is under way
  a_busy_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((|tok_valid) || pend_valid_q) |-> busy_q)
    else $error("chain active while idle");

endmodule : sorted_flow_byte_counter
`default_nettype wire
